// File: design/clws_pkg.sv
// Shared types, codes and constants for the character-LCD write sequencer.
// No dependencies; imported by clws_div10 and char_lcd_write_sequencer_core.
package clws_pkg;

    typedef enum logic [2:0] {
        ACT_INIT    = 3'd0,
        ACT_COMMAND = 3'd1,
        ACT_DATA    = 3'd2,
        ACT_CURSOR  = 3'd3,
        ACT_NUMBER  = 3'd4,
        ACT_CLEAR   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIVIDE,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic [5:0] lead_wait_ms;
        logic [1:0] trail_wait_ms;
    } init_write_t;

    localparam int NUMBER_W        = 31;
    localparam int PRODUCT_W       = 63;
    localparam int QUOTIENT_W      = 28;
    localparam int MAX_DIGITS_DEF  = 10;
    localparam int DISPLAY_COLUMNS = 16;

    // floor(n / 10) == (n * RECIP_10) >> 35 for every n below 2^32
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] DDRAM_SET        = 8'h80;
    localparam logic [7:0] ROW1_OFFSET      = 8'h40;
    localparam logic [7:0] ASCII_ZERO       = 8'h30;
    localparam logic [5:0] POWER_UP_WAIT    = 6'd50;

    localparam logic [1:0] INIT_LAST_STEP = 2'd3;

    function automatic init_write_t init_write(input logic [1:0] step);
        init_write_t w;
        case (step)
            2'd0:    w = '{CMD_FUNCTION_SET, POWER_UP_WAIT, 2'd1};
            2'd1:    w = '{CMD_DISPLAY_ON, 6'd0, 2'd1};
            2'd2:    w = '{CMD_CLEAR, 6'd0, 2'd2};
            default: w = '{CMD_ENTRY_MODE, 6'd0, 2'd1};
        endcase
        return w;
    endfunction

endpackage

// File: design/char_lcd_write_sequencer_core.sv
// Character-LCD write sequencer: requests in, one bus write per strobe out.
// Command, data, clear: one write, strobe in the cycle after start; cursor
// likewise if row <= 1 and column < 16. Init: four writes on strobe.
// Print number with n digits: one digit per cycle through the shared
// divide-by-ten multiplier, then n strobes.
// No stall from the receiver; asynchronous active-low reset returns to idle.
module char_lcd_write_sequencer_core #(
    parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    action,
    input  logic [7:0]                    byte_value,
    input  logic [7:0]                    row,
    input  logic [7:0]                    column,
    input  logic [clws_pkg::NUMBER_W-1:0] number,
    output logic                          strobe,
    output logic                          register_select,
    output logic [7:0]                    bus_byte,
    output logic [5:0]                    lead_wait_ms,
    output logic [1:0]                    trail_wait_ms,
    output logic                          last_of_run
);
    import clws_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    state_t            state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              strobe_reg, strobe_next;
    logic              rs_reg, rs_next;
    logic [7:0]        byte_reg, byte_next;
    logic [5:0]        lead_reg, lead_next;
    logic [1:0]        trail_reg, trail_next;
    logic              last_reg, last_next;
    logic [3:0]        digit_reg [MAX_DIGITS];

    logic                  div_en;
    logic [NUMBER_W-1:0]   div_in;
    logic [QUOTIENT_W-1:0] quotient;
    logic [3:0]            remainder;
    logic                  digit_we;
    logic                  digits_done;
    init_write_t           iw;

    clws_div10 u_div10 (
        .clk       (clk),
        .en        (div_en),
        .dividend  (div_in),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign div_in = (state_reg == ST_IDLE) ? number : NUMBER_W'(quotient);
    assign digits_done = (quotient == '0) || (idx_reg == IDX_W'(MAX_DIGITS - 1));

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        rs_next     = 1'b0;
        byte_next   = byte_reg;
        lead_next   = 6'd0;
        trail_next  = 2'd0;
        last_next   = 1'b0;
        div_en      = 1'b0;
        digit_we    = 1'b0;
        iw          = init_write(step_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = 1'b1;
                    case (action)
                        ACT_INIT:
                        begin
                            iw          = init_write(2'd0);
                            strobe_next = 1'b1;
                            byte_next   = iw.bus_byte;
                            lead_next   = iw.lead_wait_ms;
                            trail_next  = iw.trail_wait_ms;
                            last_next   = 1'b0;
                            step_next   = 2'd1;
                            state_next  = ST_INIT;
                        end
                        ACT_COMMAND:
                        begin
                            strobe_next = 1'b1;
                            byte_next   = byte_value;
                        end
                        ACT_DATA:
                        begin
                            strobe_next = 1'b1;
                            rs_next     = 1'b1;
                            byte_next   = byte_value;
                        end
                        ACT_CURSOR:
                        begin
                            if (row <= 8'd1 && column < 8'(DISPLAY_COLUMNS))
                            begin
                                strobe_next = 1'b1;
                                byte_next   = DDRAM_SET + (row[0] ? ROW1_OFFSET : 8'h00)
                                              + column;
                            end
                        end
                        ACT_NUMBER:
                        begin
                            div_en     = 1'b1;
                            idx_next   = '0;
                            state_next = ST_DIVIDE;
                        end
                        ACT_CLEAR:
                        begin
                            strobe_next = 1'b1;
                            byte_next   = CMD_CLEAR;
                        end
                        default:
                        begin
                            last_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                strobe_next = 1'b1;
                byte_next   = iw.bus_byte;
                lead_next   = iw.lead_wait_ms;
                trail_next  = iw.trail_wait_ms;
                last_next   = (step_reg == INIT_LAST_STEP);
                step_next   = step_reg + 2'd1;
                if (step_reg == INIT_LAST_STEP)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                // one digit per cycle, least significant first
                digit_we = 1'b1;
                if (digits_done)
                begin
                    state_next = ST_DIGITS;
                end
                else
                begin
                    div_en   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DIGITS:
            begin
                strobe_next = 1'b1;
                rs_next     = 1'b1;
                byte_next   = ASCII_ZERO + 8'(digit_reg[idx_reg]);
                last_next   = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg    <= rs_next;
        byte_reg  <= byte_next;
        lead_reg  <= lead_next;
        trail_reg <= trail_next;
        last_reg  <= last_next;
        if (digit_we)
        begin
            digit_reg[idx_reg] <= remainder;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign strobe          = strobe_reg;
    assign register_select = rs_reg;
    assign bus_byte        = byte_reg;
    assign lead_wait_ms    = lead_reg;
    assign trail_wait_ms   = trail_reg;
    assign last_of_run     = last_reg;

endmodule

// File: design/clws_div10.sv
// Shared divide-by-ten unit: reciprocal multiply, product registered.
// Quotient and remainder are valid the cycle after en. Uses clws_pkg.
module clws_div10 (
    input  logic                             clk,
    input  logic                             en,
    input  logic [clws_pkg::NUMBER_W-1:0]    dividend,
    output logic [clws_pkg::QUOTIENT_W-1:0]  quotient,
    output logic [3:0]                       remainder
);
    import clws_pkg::*;

    logic [NUMBER_W-1:0]  dividend_reg;
    logic [PRODUCT_W-1:0] prod_reg;
    logic [3:0]           q10_low;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dividend_reg <= dividend;
            prod_reg     <= PRODUCT_W'(dividend) * PRODUCT_W'(RECIP_10);
        end
    end

    assign quotient = prod_reg[RECIP_SHIFT +: QUOTIENT_W];

    // true remainder is below ten, so four low bits of n - 10q are enough
    assign q10_low   = 4'({quotient[0], 3'b000}) + 4'({quotient[2:0], 1'b0});
    assign remainder = dividend_reg[3:0] - q10_low;

endmodule
